FILE: rtl/pec15_frame_engine_core_defines.svh
// Assertion macros shared by the PEC frame engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PEC15_FRAME_ENGINE_CORE_DEFINES_SVH
`define PEC15_FRAME_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pfe_pkg.sv
// Shared constants for the PEC frame engine.
// No dependencies.
package pfe_pkg;

  localparam int unsigned DefMaxDevices = 16;
  localparam int unsigned GroupIdxW     = 4;
  localparam int unsigned RemW          = 16;

  localparam logic [RemW-1:0] PecSeed = 16'd16;
  localparam logic [RemW-1:0] PecPoly = 16'h4599;

endpackage

FILE: rtl/pfe_ifs.sv
// Input and result channels of the PEC frame engine (valid/ready).
// Depends on pfe_pkg for the group index width.
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       group_end;
  logic       frame_start;

  modport source (output valid, output op, output data_byte, output group_end,
                  output frame_start, input ready);
  modport sink   (input valid, input op, input data_byte, input group_end,
                  input frame_start, output ready);
endinterface

interface pfe_out_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      out_byte;
  logic                            is_status;
  logic                            pec_error;
  logic [pfe_pkg::GroupIdxW-1:0]   group_index;
  logic                            last;

  modport source (output valid, output out_byte, output is_status, output pec_error,
                  output group_index, output last, input ready);
  modport sink   (input valid, input out_byte, input is_status, input pec_error,
                  input group_index, input last, output ready);
endinterface

FILE: rtl/pfe_crc_step.sv
// One CRC-15 byte step of the PEC remainder, bitwise form of the byte table.
// Depends on pfe_pkg.
module pfe_crc_step (
  input  logic [pfe_pkg::RemW-1:0] rem_i,
  input  logic [7:0]               byte_i,
  output logic [pfe_pkg::RemW-1:0] rem_o
);
  import pfe_pkg::*;

  logic [7:0]      addr;
  logic [RemW-1:0] tbl;

  assign addr = rem_i[14:7] ^ byte_i;

  // eight shift/xor steps on the table index
  always_comb begin
    tbl = {1'b0, addr, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (tbl[14]) begin
        tbl = {tbl[RemW-2:0], 1'b0} ^ PecPoly;
      end else begin
        tbl = {tbl[RemW-2:0], 1'b0};
      end
    end
  end

  assign rem_o = {rem_i[7:0], 8'b0} ^ tbl;

endmodule

FILE: rtl/pec15_frame_engine_core.sv
// PEC frame engine top level. Depends on pfe_pkg, pfe_ifs, pfe_crc_step and
// pec15_frame_engine_core_defines.svh.
// The echo beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while the result register is free; a send group
// end adds two PEC beats and a receive group end one status beat, during which input is held off.
// Reset (async, active low): remainder to seed 16, group counter to 0, no beats.
module pec15_frame_engine_core #(
  parameter int unsigned MaxDevices = pfe_pkg::DefMaxDevices
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pfe_in_if.sink   in_i,
  pfe_out_if.source out_o
);
  import pfe_pkg::*;
  `include "pec15_frame_engine_core_defines.svh"

  localparam logic [GroupIdxW-1:0] LastGroup = GroupIdxW'(MaxDevices - 1);

  // running state
  logic [RemW-1:0]      rem_q;
  logic [GroupIdxW-1:0] group_q;

  // result register
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 is_status_q;
  logic                 pec_error_q;
  logic [GroupIdxW-1:0] group_index_q;
  logic                 last_q;

  // beats still owed for the current item (PEC bytes or status)
  logic [1:0]           pend_cnt_q;
  logic                 pend_send_q;
  logic [RemW-1:0]      pend_pec_q;
  logic [GroupIdxW-1:0] pend_gidx_q;

  logic                 out_load;
  logic                 in_ready;
  logic                 accept;
  logic [RemW-1:0]      rem_base;
  logic [RemW-1:0]      rem_upd;
  logic [RemW-1:0]      pec;
  logic [GroupIdxW-1:0] gidx;
  logic [GroupIdxW-1:0] group_next;

  // result register frees when empty or being taken
  assign out_load = !out_valid_q || out_o.ready;
  assign in_ready = (pend_cnt_q == 2'd0) && out_load;
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // frame start reseeds before the byte goes in
  assign rem_base = in_i.frame_start ? PecSeed : rem_q;
  assign gidx     = in_i.frame_start ? '0 : group_q;

  pfe_crc_step u_crc_step (
    .rem_i  (rem_base),
    .byte_i (in_i.data_byte),
    .rem_o  (rem_upd)
  );

  assign pec        = {rem_upd[RemW-2:0], 1'b0};
  assign group_next = (gidx == LastGroup) ? '0 : gidx + 1'b1;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= PecSeed;
      group_q     <= '0;
      out_valid_q <= 1'b0;
      pend_cnt_q  <= 2'd0;
    end else begin
      if (accept) begin
        rem_q   <= in_i.group_end ? PecSeed : rem_upd;
        group_q <= (in_i.group_end && in_i.op) ? group_next : gidx;
      end
      if (out_load) begin
        if (pend_cnt_q != 2'd0) begin
          out_valid_q <= 1'b1;
          pend_cnt_q  <= pend_cnt_q - 2'd1;
        end else if (accept) begin
          out_valid_q <= 1'b1;
          if (in_i.group_end) begin
            pend_cnt_q <= in_i.op ? 2'd1 : 2'd2;
          end
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_send_q <= !in_i.op;
      pend_pec_q  <= pec;
      pend_gidx_q <= gidx;
    end
    if (out_load) begin
      if (pend_cnt_q != 2'd0) begin
        group_index_q <= pend_gidx_q;
        if (pend_send_q) begin
          out_byte_q  <= (pend_cnt_q == 2'd2) ? pend_pec_q[15:8] : pend_pec_q[7:0];
          is_status_q <= 1'b0;
          pec_error_q <= 1'b0;
          last_q      <= (pend_cnt_q == 2'd1);
        end else begin
          out_byte_q  <= 8'h00;
          is_status_q <= 1'b1;
          pec_error_q <= |pend_pec_q;
          last_q      <= 1'b1;
        end
      end else if (accept) begin
        out_byte_q    <= in_i.data_byte;
        is_status_q   <= 1'b0;
        pec_error_q   <= 1'b0;
        group_index_q <= gidx;
        last_q        <= !in_i.group_end;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.is_status   = is_status_q;
  assign out_o.pec_error   = pec_error_q;
  assign out_o.group_index = group_index_q;
  assign out_o.last        = last_q;

  `PFE_ASSERT_NOW(a_no_accept_while_owed, clk_i, rst_ni,
    in_i.valid && in_i.ready, pend_cnt_q == 2'd0, "input beat taken with beats owed")
  `PFE_ASSERT_NOW(a_owed_needs_valid, clk_i, rst_ni,
    pend_cnt_q != 2'd0, out_valid_q, "owed beats behind an empty result register")
  `PFE_ASSERT_NEXT(a_send_end_owes_two, clk_i, rst_ni,
    accept && in_i.group_end && !in_i.op, pend_cnt_q == 2'd2 && out_valid_q && !last_q,
    "send group end did not queue two PEC beats")
  `PFE_ASSERT_NOW(a_status_shape, clk_i, rst_ni,
    out_valid_q && is_status_q, out_byte_q == 8'h00 && last_q && pend_cnt_q == 2'd0,
    "malformed status beat")
  `PFE_ASSERT_NOW(a_group_range, clk_i, rst_ni,
    1'b1, group_q <= LastGroup, "group counter beyond device count")

endmodule
